### rtl/tccs_pkg.sv
// Shared types and constants for the text console cursor and scroll block.
// Used by tccs_ctrl, tccs_data and text_console_cursor_scroll; depends on nothing.
package tccs_pkg;

  localparam int unsigned COL_FIELD_W = 7;
  localparam int unsigned ROW_FIELD_W = 5;
  localparam int unsigned IN_DATA_W   = 24;
  localparam int unsigned OUT_DATA_W  = 32;

  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h0F;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] RETURN_CODE  = 8'h0D;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef struct packed {
    logic exec;
    logic fill;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic need_fill;
    logic fill_done;
    logic out_busy;
  } status_t;

endpackage

### rtl/tccs_ctrl.sv
// Controller state machine of the text console: sequences request execution,
// fill sweeps and result hand-off. Depends on tccs_pkg.
module tccs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tccs_pkg::status_t status,
  output tccs_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_INIT = 4'b0001,
    S_IDLE = 4'b0010,
    S_FILL = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_INIT: begin
        cmd.fill = 1'b1;
        if (status.fill_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.exec   = 1'b1;
          state_next = status.need_fill ? S_FILL : S_DONE;
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (status.fill_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

### rtl/tccs_data.sv
// Datapath of the text console: cell memory, cursor, row base offset, fill
// sweep counter, attribute register and result register. Depends on tccs_pkg.
module tccs_data #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tccs_pkg::cmd_t                     cmd,
  output tccs_pkg::status_t                  status,
  input  logic                               cfg_we,
  input  logic [7:0]                         cfg_wdata,
  input  logic [1:0]                         op,
  input  logic [7:0]                         char_code,
  input  logic [tccs_pkg::ROW_FIELD_W-1:0]   cell_row,
  input  logic [tccs_pkg::COL_FIELD_W-1:0]   cell_col,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [tccs_pkg::COL_FIELD_W-1:0]   out_col,
  output logic [tccs_pkg::ROW_FIELD_W-1:0]   out_row,
  output logic                               out_scrolled,
  output logic [7:0]                         out_char,
  output logic [7:0]                         out_attr
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned AW    = $clog2(CELLS);

  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata;
  logic [7:0]    text_attribute;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic [RW-1:0] base;
  logic [AW-1:0] fill_addr;
  logic [AW-1:0] fill_last;
  logic [15:0]   fill_cell;
  logic          res_scrolled;
  logic          res_read;

  logic          is_put;
  logic          is_clear;
  logic          is_read;
  logic          is_newline;
  logic          is_return;
  logic          at_last_col;
  logic          at_last_row;
  logic          line_feed;
  logic          scroll;
  logic          write_char;
  logic          read_ok;
  logic [RW-1:0] rd_row;
  logic [RW-1:0] rd_phys;
  logic [RW-1:0] cur_phys;
  logic [RW:0]   rd_sum;
  logic [RW:0]   cur_sum;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] row_start;

  assign is_put      = (op == tccs_pkg::OP_PUT);
  assign is_clear    = (op == tccs_pkg::OP_CLEAR);
  assign is_read     = (op == tccs_pkg::OP_READ);
  assign is_newline  = (char_code == tccs_pkg::NEWLINE_CODE);
  assign is_return   = (char_code == tccs_pkg::RETURN_CODE);
  assign at_last_col = (cur_col == CW'(COLUMNS - 1));
  assign at_last_row = (cur_row == RW'(ROWS - 1));
  assign write_char  = is_put && !is_newline && !is_return;
  assign line_feed   = is_put && (is_newline || (write_char && at_last_col));
  assign scroll      = line_feed && at_last_row;
  assign read_ok     = is_read && (32'(cell_row) < ROWS) && (32'(cell_col) < COLUMNS);

  // Logical rows map onto physical rows rotated by the base offset.
  assign rd_row   = RW'(cell_row);
  assign rd_sum   = {1'b0, rd_row} + {1'b0, base};
  assign rd_phys  = (32'(rd_sum) >= ROWS) ? RW'(32'(rd_sum) - ROWS) : rd_sum[RW-1:0];
  assign cur_sum  = {1'b0, cur_row} + {1'b0, base};
  assign cur_phys = (32'(cur_sum) >= ROWS) ? RW'(32'(cur_sum) - ROWS) : cur_sum[RW-1:0];
  assign rd_addr   = AW'(32'(rd_phys) * COLUMNS + 32'(RW'(0)) + 32'(CW'(cell_col)));
  assign wr_addr   = AW'(32'(cur_phys) * COLUMNS + 32'(cur_col));
  assign row_start = AW'(32'(base) * COLUMNS);

  assign status.need_fill = is_clear || scroll;
  assign status.fill_done = (fill_addr == fill_last);
  assign status.out_busy  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.exec && is_put && write_char) begin
      mem[wr_addr] <= {text_attribute, char_code};
    end else if (cmd.fill) begin
      mem[fill_addr] <= fill_cell;
    end
    if (cmd.exec) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= tccs_pkg::RESET_ATTR;
    end else if (cfg_we) begin
      text_attribute <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col      <= '0;
      cur_row      <= '0;
      base         <= '0;
      fill_addr    <= '0;
      fill_last    <= AW'(CELLS - 1);
      fill_cell    <= {tccs_pkg::RESET_ATTR, tccs_pkg::BLANK_CHAR};
      res_scrolled <= 1'b0;
      res_read     <= 1'b0;
    end else if (cmd.exec) begin
      res_scrolled <= scroll;
      res_read     <= read_ok;
      if (is_clear) begin
        cur_col   <= '0;
        cur_row   <= '0;
        base      <= '0;
        fill_addr <= '0;
        fill_last <= AW'(CELLS - 1);
        fill_cell <= {text_attribute, tccs_pkg::BLANK_CHAR};
      end else if (is_put) begin
        if (line_feed) begin
          cur_col <= '0;
          if (scroll) begin
            base      <= (base == RW'(ROWS - 1)) ? '0 : base + RW'(1);
            fill_addr <= row_start;
            fill_last <= row_start + AW'(COLUMNS - 1);
            fill_cell <= {text_attribute, tccs_pkg::BLANK_CHAR};
          end else begin
            cur_row <= cur_row + RW'(1);
          end
        end else if (is_return) begin
          cur_col <= '0;
        end else begin
          cur_col <= cur_col + CW'(1);
        end
      end
    end else if (cmd.fill && !status.fill_done) begin
      fill_addr <= fill_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_col      <= tccs_pkg::COL_FIELD_W'(cur_col);
      out_row      <= tccs_pkg::ROW_FIELD_W'(cur_row);
      out_scrolled <= res_scrolled;
      out_char     <= res_read ? rdata[7:0] : 8'h00;
      out_attr     <= res_read ? rdata[15:8] : 8'h00;
    end
  end

endmodule

### rtl/text_console_cursor_scroll.sv
// Top level of the text console writer: stream ports, attribute register port.
// Instantiates tccs_ctrl and tccs_data; depends on tccs_pkg.

// A printable character, a carriage return, a newline that does not scroll, a cell
// read and an unused operation code go from acceptance to the result hand-off with
// no fill sweep. A request that moves the cursor past the bottom row first sweeps
// the blanked bottom line cell by cell, since scrolling only advances a row base
// offset and the single memory write port sweeps the freed row. A clear first
// sweeps over every cell. After reset the block runs the same sweep over every
// cell before it accepts its first request; attribute writes are taken
// throughout. A new request is accepted while the previous result waits in the
// output register.
module text_console_cursor_scroll #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [7:0]                       cfg_wdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // char_code[7:0], cell_row[12:8], cell_col[19:13], zero fill above.
  input  logic [tccs_pkg::IN_DATA_W-1:0]   s_tdata,
  // operation[1:0].
  input  logic [1:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // cursor_col[6:0], cursor_row[11:7], scrolled[12], read_char[20:13],
  // read_attr[28:21], zero fill above.
  output logic [tccs_pkg::OUT_DATA_W-1:0]  m_tdata
);

  tccs_pkg::cmd_t    cmd;
  tccs_pkg::status_t status;

  logic [tccs_pkg::COL_FIELD_W-1:0] out_col;
  logic [tccs_pkg::ROW_FIELD_W-1:0] out_row;
  logic                             out_scrolled;
  logic [7:0]                       out_char;
  logic [7:0]                       out_attr;

  tccs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tccs_data #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_data (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .op           (s_tuser),
    .char_code    (s_tdata[7:0]),
    .cell_row     (s_tdata[12:8]),
    .cell_col     (s_tdata[19:13]),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_col      (out_col),
    .out_row      (out_row),
    .out_scrolled (out_scrolled),
    .out_char     (out_char),
    .out_attr     (out_attr)
  );

  assign m_tdata = {3'b000, out_attr, out_char, out_scrolled, out_row, out_col};

endmodule

### test/tb_top.sv
// Self-checking testbench for text_console_cursor_scroll: a scoreboard class tracks the
// screen, cursor and attribute and checks every result; plain tasks drive the input stream.
// Depends on tccs_pkg and the text_console_cursor_scroll RTL only.

module tb_top;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] chr;
    logic       scrolled;
    logic [4:0] row;
    logic [6:0] col;
  } cursor_result_t;

  class screen_tracker;
    logic [15:0]    cells [ROWS*COLUMNS];
    int             cur_col;
    int             cur_row;
    logic [7:0]     text_attr;
    cursor_result_t pending_results [$];
    int             mismatches;

    function new();
      foreach (cells[i]) cells[i] = {tccs_pkg::RESET_ATTR, tccs_pkg::BLANK_CHAR};
      cur_col = 0;
      cur_row = 0;
      text_attr = tccs_pkg::RESET_ATTR;
      mismatches = 0;
    endfunction

    function void blank_cells(int first, int count);
      for (int i = first; i < first + count; i++) cells[i] = {text_attr, tccs_pkg::BLANK_CHAR};
    endfunction

    function logic advance_line();
      cur_col = 0;
      cur_row++;
      if (cur_row >= ROWS) begin
        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) cells[i] = cells[i + COLUMNS];
        blank_cells((ROWS - 1) * COLUMNS, COLUMNS);
        cur_row = ROWS - 1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_request(logic [1:0] op, logic [7:0] ch, logic [4:0] rrow,
                               logic [6:0] rcol);
      cursor_result_t want;
      want = '0;
      case (op)
        tccs_pkg::OP_PUT: begin
          if (ch == tccs_pkg::NEWLINE_CODE) begin
            want.scrolled = advance_line();
          end else if (ch == tccs_pkg::RETURN_CODE) begin
            cur_col = 0;
          end else begin
            cells[cur_row * COLUMNS + cur_col] = {text_attr, ch};
            cur_col++;
            if (cur_col >= COLUMNS) want.scrolled = advance_line();
          end
        end
        tccs_pkg::OP_CLEAR: begin
          blank_cells(0, ROWS * COLUMNS);
          cur_col = 0;
          cur_row = 0;
        end
        tccs_pkg::OP_READ: begin
          if (rrow < ROWS && rcol < COLUMNS) begin
            want.chr  = cells[rrow * COLUMNS + rcol][7:0];
            want.attr = cells[rrow * COLUMNS + rcol][15:8];
          end
        end
        default: ;
      endcase
      want.col = cur_col[6:0];
      want.row = cur_row[4:0];
      pending_results.push_back(want);
    endfunction

    function void log_failure(string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t mismatch: %s", $time, what);
    endfunction

    function void check_result(logic [31:0] word);
      cursor_result_t got;
      cursor_result_t want;
      got = word[28:0];
      if (pending_results.size() == 0) begin
        log_failure($sformatf("unexpected result col %0d row %0d scrolled %0d char %h attr %h",
                              got.col, got.row, got.scrolled, got.chr, got.attr));
        return;
      end
      want = pending_results.pop_front();
      if (got.col !== want.col || got.row !== want.row || got.scrolled !== want.scrolled ||
          got.chr !== want.chr || got.attr !== want.attr)
        log_failure($sformatf({"expected col %0d row %0d scrolled %0d char %h attr %h, ",
                               "got col %0d row %0d scrolled %0d char %h attr %h"},
                              want.col, want.row, want.scrolled, want.chr, want.attr,
                              got.col, got.row, got.scrolled, got.chr, got.attr));
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [7:0]                      cfg_wdata = '0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [tccs_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]                      s_tuser = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [tccs_pkg::OUT_DATA_W-1:0] m_tdata;

  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned beat_count = 0;

  screen_tracker board = new();

  text_console_cursor_scroll #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(3);
      stall_left <= $urandom_range(300, 40);
    end else begin
      stall_left <= stall_left - 1;
    end
    beat_count <= beat_count + 1;
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(1));
      2: m_tready <= (beat_count % 4 != 3);
      default: m_tready <= ($urandom_range(7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  task automatic send_request(logic [1:0] op, logic [7:0] ch, logic [4:0] rrow,
                              logic [6:0] rcol);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, rcol, rrow, ch};
    do @(posedge clk); while (!s_tready);
    board.note_request(op, ch, rrow, rcol);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_attribute(logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.text_attr = value;
  endtask

  task automatic run_random(int count);
    int unsigned pick;
    int          burst_left;
    logic [1:0]  op;
    logic [7:0]  ch;
    logic [4:0]  rrow;
    logic [6:0]  rcol;
    burst_left = $urandom_range(40, 1);
    repeat (count) begin
      pick = $urandom_range(99);
      ch   = 8'($urandom_range(255));
      rrow = 5'($urandom_range(31));
      rcol = 7'($urandom_range(127));
      if (pick < 1) begin
        op = tccs_pkg::OP_CLEAR;
      end else if (pick < 4) begin
        op = OP_UNUSED;
      end else if (pick < 26) begin
        op = tccs_pkg::OP_READ;
        if ($urandom_range(9) != 0) rrow = 5'($urandom_range(ROWS - 1));
        if ($urandom_range(9) != 0) rcol = 7'($urandom_range(COLUMNS - 1));
      end else begin
        op = tccs_pkg::OP_PUT;
        pick = $urandom_range(99);
        if (pick < 12) ch = tccs_pkg::NEWLINE_CODE;
        else if (pick < 16) ch = tccs_pkg::RETURN_CODE;
      end
      send_request(op, ch, rrow, rcol);
      burst_left--;
      if (burst_left == 0) begin
        idle_cycles(($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1));
        burst_left = $urandom_range(40, 1);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Untouched screen, out-of-range reads, control bytes, byte zero and the unused code.
    send_request(tccs_pkg::OP_READ, 8'h00, 5'd0, 7'd0);
    send_request(tccs_pkg::OP_READ, 8'hFF, 5'd24, 7'd79);
    send_request(tccs_pkg::OP_READ, 8'h00, 5'd25, 7'd0);
    send_request(tccs_pkg::OP_READ, 8'h00, 5'd0, 7'd80);
    send_request(tccs_pkg::OP_READ, 8'h00, 5'd31, 7'd127);
    send_request(tccs_pkg::OP_PUT, 8'h41, 5'd31, 7'd127);
    send_request(tccs_pkg::OP_PUT, 8'h00, 5'd0, 7'd0);
    send_request(tccs_pkg::OP_PUT, 8'hFF, 5'd0, 7'd0);
    send_request(tccs_pkg::OP_PUT, tccs_pkg::NEWLINE_CODE, 5'd0, 7'd0);
    send_request(tccs_pkg::OP_PUT, 8'h7E, 5'd0, 7'd0);
    send_request(tccs_pkg::OP_PUT, tccs_pkg::RETURN_CODE, 5'd0, 7'd0);
    send_request(OP_UNUSED, 8'hFF, 5'd31, 7'd127);
    send_request(tccs_pkg::OP_READ, 8'h00, 5'd0, 7'd0);
    send_request(tccs_pkg::OP_READ, 8'h00, 5'd0, 7'd1);
    send_request(tccs_pkg::OP_READ, 8'h00, 5'd0, 7'd2);
    send_request(tccs_pkg::OP_READ, 8'h00, 5'd1, 7'd0);
    drain_results();

    write_attribute(8'h00);
    send_request(tccs_pkg::OP_CLEAR, 8'hFF, 5'd31, 7'd127);
    send_request(tccs_pkg::OP_READ, 8'h00, 5'd0, 7'd0);
    send_request(tccs_pkg::OP_READ, 8'h00, 5'd24, 7'd79);
    send_request(tccs_pkg::OP_PUT, 8'h5A, 5'd0, 7'd0);
    send_request(tccs_pkg::OP_READ, 8'h00, 5'd0, 7'd0);
    drain_results();

    write_attribute(8'hFF);
    run_random(320);
    drain_results();
    write_attribute(8'h00);
    run_random(320);
    drain_results();
    write_attribute(8'($urandom_range(255)));
    run_random(320);
    drain_results();
    write_attribute(8'($urandom_range(255)));
    run_random(320);
    drain_results();
    write_attribute(tccs_pkg::RESET_ATTR);
    run_random(320);
    drain_results();

    repeat (COLUMNS + 20) @(posedge clk);
    if (board.mismatches == 0 && board.pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

### filelist.f
rtl/tccs_pkg.sv
rtl/tccs_ctrl.sv
rtl/tccs_data.sv
rtl/text_console_cursor_scroll.sv
test/tb_top.sv
